// ===== rtl/html_entity_decoder_defines.svh =====
// assertion macros for the html entity decoder
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

// condition holds whenever the antecedent holds in the same cycle
`define HED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the antecedent
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hed_pkg.sv =====
// package of constants, entity tables and shared types for the entity decoder
package hed_pkg;

    localparam int OUTPUT_CAPACITY = 1024;
    localparam int CNT_W           = $clog2(OUTPUT_CAPACITY);
    localparam int CMP_W           = (CNT_W > 3) ? CNT_W : 3;
    localparam int HOLD_MAX        = 5;
    localparam int RES_MAX         = HOLD_MAX + 1;
    localparam int ENT_COUNT       = 5;
    localparam int ENT_MAX_LEN     = 6;

    localparam logic [7:0] AMP_CHAR = 8'h26;

    localparam logic [7:0] ENT_TEXT [ENT_COUNT][ENT_MAX_LEN] = '{
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
        '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3b, 8'h00}
    };
    localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
    localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

    typedef struct packed {
        logic [HOLD_MAX-1:0][7:0] bytes;
        logic [2:0]               count;
        logic [CNT_W-1:0]         emitted;
        logic                     overflow;
    } hold_state_t;

    typedef struct packed {
        logic [RES_MAX-1:0][7:0] chars;
        logic [2:0]              count;
        logic                    char_valid;
        logic                    eos;
        logic                    trunc;
    } res_batch_t;

endpackage

// ===== rtl/hed_match.sv =====
// entity matcher: builds the result batch and next hold state for one input byte
module hed_match (
    input  hed_pkg::hold_state_t st,
    input  logic [7:0]           in_char,
    input  logic                 last,
    output hed_pkg::hold_state_t st_next,
    output hed_pkg::res_batch_t  batch
);
    import hed_pkg::*;

    always_comb
    begin
        logic [2:0]       len;
        logic [7:0]       win_c [RES_MAX];
        logic             m;
        logic             hit;
        logic             pref;
        logic [7:0]       hit_char;
        logic [2:0]       n;
        logic [CMP_W-1:0] avail;
        logic [CMP_W-1:0] n_x;
        logic [2:0]       d;
        logic             over;
        logic             ovf_str;

        len = st.count + 3'd1;
        for (int i = 0; i < RES_MAX; i++)
        begin
            win_c[i] = in_char;
            if (i < HOLD_MAX)
            begin
                if (3'(i) < st.count)
                begin
                    win_c[i] = st.bytes[i];
                end
            end
        end

        hit      = 1'b0;
        pref     = 1'b0;
        hit_char = 8'h00;
        for (int e = 0; e < ENT_COUNT; e++)
        begin
            m = (len <= ENT_LEN[e]);
            for (int i = 0; i < ENT_MAX_LEN; i++)
            begin
                if (3'(i) < len && win_c[i] != ENT_TEXT[e][i])
                begin
                    m = 1'b0;
                end
            end
            if (m && len == ENT_LEN[e])
            begin
                hit      = 1'b1;
                hit_char = ENT_CHAR[e];
            end
            if (m && len < ENT_LEN[e])
            begin
                pref = 1'b1;
            end
        end

        st_next = st;
        for (int i = 0; i < RES_MAX; i++)
        begin
            batch.chars[i] = win_c[i];
        end

        if (hit)
        begin
            batch.chars[0] = hit_char;
            n              = 3'd1;
            st_next.count  = 3'd0;
        end
        else if (pref && st.count < 3'(HOLD_MAX))
        begin
            if (last)
            begin
                n             = len;
                st_next.count = 3'd0;
            end
            else
            begin
                n = 3'd0;
                for (int i = 0; i < HOLD_MAX; i++)
                begin
                    if (3'(i) == st.count)
                    begin
                        st_next.bytes[i] = in_char;
                    end
                end
                st_next.count = len;
            end
        end
        else if (in_char == AMP_CHAR && !last)
        begin
            n                = st.count;
            st_next.bytes[0] = in_char;
            st_next.count    = 3'd1;
        end
        else
        begin
            n             = len;
            st_next.count = 3'd0;
        end

        // capacity check on the whole batch
        avail   = CMP_W'(OUTPUT_CAPACITY - 1) - CMP_W'(st.emitted);
        n_x     = CMP_W'(n);
        over    = (n_x > avail);
        d       = over ? avail[2:0] : n;
        ovf_str = st.overflow | over;

        if (last)
        begin
            st_next.bytes    = '0;
            st_next.emitted  = '0;
            st_next.overflow = 1'b0;
        end
        else
        begin
            st_next.emitted  = CNT_W'(CMP_W'(st.emitted) + CMP_W'(d));
            st_next.overflow = ovf_str;
        end

        batch.eos        = last;
        batch.trunc      = ovf_str;
        batch.char_valid = 1'b1;
        batch.count      = d;
        if (last && d == 3'd0)
        begin
            batch.chars[0]   = 8'h00;
            batch.char_valid = 1'b0;
            batch.count      = 3'd1;
        end
    end

endmodule

// ===== rtl/hed_obuf.sv =====
// result buffer: holds one item's batch of results and sends them one per cycle while the receiver is ready
module hed_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hed_pkg::res_batch_t batch,
    output logic                ready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // out_char
    output logic                m_axis_tlast,   // end_of_string
    output logic [1:0]          m_axis_tuser    // char_valid, truncated
);
    import hed_pkg::*;

    logic [RES_MAX-1:0][7:0] chars_reg;
    logic [2:0]              rem_reg;
    logic                    cv_reg;
    logic                    eos_reg;
    logic                    trunc_reg;
    logic                    pop;

    assign m_axis_tvalid = (rem_reg != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign ready         = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_axis_tready);

    assign m_axis_tdata  = chars_reg[0];
    assign m_axis_tlast  = eos_reg && (rem_reg == 3'd1);
    assign m_axis_tuser  = {m_axis_tlast && trunc_reg, cv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
        end
        else if (load)
        begin
            rem_reg <= batch.count;
        end
        else if (pop)
        begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= batch.chars;
            cv_reg    <= batch.char_valid;
            eos_reg   <= batch.eos;
            trunc_reg <= batch.trunc;
        end
        else if (pop)
        begin
            chars_reg <= chars_reg >> 8;
        end
    end

endmodule

// ===== rtl/html_entity_decoder.sv =====
// the first result of an accepted item is offered in the next cycle
// throughput: one item per cycle while each item gives at most one result and the receiver is ready
// an item that releases k held bytes gives k results on the result port,
// and the input is held off while all but the last of them drain
// reset (async, active low) clears the hold, the string counters and the result buffer
`include "html_entity_decoder_defines.svh"

module html_entity_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_char
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_char
    output logic       m_axis_tlast,   // end_of_string
    output logic [1:0] m_axis_tuser    // char_valid, truncated
);
    import hed_pkg::*;

    hold_state_t state_reg;
    hold_state_t state_next;
    res_batch_t  batch;
    logic        accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    hed_match u_match (
        .st      (state_reg),
        .in_char (s_axis_tdata),
        .last    (s_axis_tlast),
        .st_next (state_next),
        .batch   (batch)
    );

    hed_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .batch         (batch),
        .ready         (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    `HED_ASSERT_NOW(a_hold_bound, 1'b1, state_reg.count <= 3'(HOLD_MAX), "hold count above limit")
    `HED_ASSERT_NOW(a_emit_bound, 1'b1, CMP_W'(state_reg.emitted) <= CMP_W'(OUTPUT_CAPACITY - 1), "emitted count above capacity")
    `HED_ASSERT_NEXT(a_end_clears, accept && s_axis_tlast, state_reg.count == 3'd0 && state_reg.emitted == '0 && !state_reg.overflow, "string state not cleared at end")
    `HED_ASSERT_NOW(a_bare_end, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "bare marker without end flag")

endmodule

// ===== dv/html_entity_decoder_test.sv =====
// self-checking stream testbench for the html entity decoder
`timescale 1ns / 1ps

module html_entity_decoder_test;

    localparam int CAPACITY  = 1024;
    localparam int HOLD_MAX  = 5;
    localparam int RAND_BYTES = 120;
    localparam int LONG_STALL = 200;
    localparam int TAIL_WAIT = 20;
    localparam int LIMIT     = 400000;
    localparam logic [7:0] AMP = 8'h26;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       eos;
        logic       trunc;
    } decoded_char_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          lst;
        logic          typed;
        decoded_char_t want;
    } stim_row_t;

    localparam int PLAN_N = 27;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // in_char
    logic       s_axis_tlast = 1'b0;    // last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // out_char
    logic       m_axis_tlast;           // end_of_string
    logic [1:0] m_axis_tuser;           // char_valid, truncated

    string      entity_text [5] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#39;"};
    logic [7:0] entity_char [5] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

    // predictor state
    logic [7:0] hold_q [HOLD_MAX];
    int         hold_n = 0;
    int         sent_n = 0;
    bit         dropped = 0;

    decoded_char_t step_res [$];
    decoded_char_t expected_chars [$];

    int  errors = 0;
    int  cycle_cnt = 0;
    int  strings_sent = 0;
    int  bytes_sent = 0;
    int  chars_checked = 0;
    int  stall_asks = 0;
    int  stall_taken = 0;
    int  stall_left = 0;
    bit  calm = 0;

    stim_row_t plan [PLAN_N] = '{
        '{"A",   1'b1, 1'b1, '{"A",   1'b1, 1'b1, 1'b0}},
        '{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b0}},
        // zero byte is a plain literal
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{"&",   1'b0, 1'b0, '0},
        '{"l",   1'b0, 1'b0, '0},
        '{"t",   1'b0, 1'b0, '0},
        '{";",   1'b1, 1'b1, '{"<",   1'b1, 1'b1, 1'b0}},
        // full hold broken by a plain byte
        '{"&",   1'b0, 1'b0, '0},
        '{"q",   1'b0, 1'b0, '0},
        '{"u",   1'b0, 1'b0, '0},
        '{"o",   1'b0, 1'b0, '0},
        '{"t",   1'b0, 1'b0, '0},
        '{"X",   1'b0, 1'b0, '0},
        // ampersand restarts the match
        '{"&",   1'b0, 1'b0, '0},
        '{"&",   1'b0, 1'b0, '0},
        '{"a",   1'b0, 1'b0, '0},
        '{"m",   1'b0, 1'b0, '0},
        '{"p",   1'b0, 1'b0, '0},
        '{";",   1'b0, 1'b0, '0},
        // held bytes flushed at end of string, then an entity that ends a string
        '{"&",   1'b0, 1'b0, '0},
        '{"g",   1'b0, 1'b0, '0},
        '{"t",   1'b1, 1'b0, '0},
        '{"&",   1'b0, 1'b0, '0},
        '{"#",   1'b0, 1'b0, '0},
        '{"3",   1'b0, 1'b0, '0},
        '{"9",   1'b0, 1'b0, '0},
        '{";",   1'b1, 1'b0, '0}
    };

    html_entity_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic void emit_char(logic [7:0] ch);
        if (sent_n < CAPACITY - 1)
        begin
            step_res.push_back('{ch, 1'b1, 1'b0, 1'b0});
            sent_n++;
        end
        else
        begin
            dropped = 1;
        end
    endfunction

    function automatic void release_hold();
        for (int i = 0; i < hold_n; i++)
            emit_char(hold_q[i]);
        hold_n = 0;
    endfunction

    function automatic void decode_byte(logic [7:0] c, logic lst);
        logic [7:0] seq [HOLD_MAX+1];
        int         seq_n;
        int         hit;
        bit         partial;
        bit         same;
        hit = -1;
        partial = 0;
        for (int i = 0; i < hold_n; i++)
            seq[i] = hold_q[i];
        seq[hold_n] = c;
        seq_n = hold_n + 1;
        for (int e = 0; e < 5; e++)
        begin
            if (seq_n <= entity_text[e].len())
            begin
                same = 1;
                for (int i = 0; i < seq_n; i++)
                    if (entity_text[e][i] != seq[i])
                        same = 0;
                if (same && seq_n == entity_text[e].len())
                    hit = e;
                else if (same)
                    partial = 1;
            end
        end
        if (hit >= 0)
        begin
            hold_n = 0;
            emit_char(entity_char[hit]);
        end
        else if (partial && hold_n < HOLD_MAX)
        begin
            hold_q[hold_n] = c;
            hold_n++;
        end
        else
        begin
            release_hold();
            if (c == AMP)
            begin
                hold_q[0] = c;
                hold_n = 1;
            end
            else
            begin
                emit_char(c);
            end
        end
        if (lst)
        begin
            release_hold();
            if (step_res.size() == 0)
            begin
                step_res.push_back('{8'h00, 1'b0, 1'b1, dropped});
            end
            else
            begin
                step_res[step_res.size()-1].eos = 1'b1;
                step_res[step_res.size()-1].trunc = dropped;
            end
            sent_n = 0;
            dropped = 0;
        end
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("error at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, field, got, want);
        errors++;
    endtask

    // called at a rising edge, returns at the rising edge that accepts the item
    task automatic send_item(logic [7:0] ch, logic lst, logic typed, decoded_char_t want);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        step_res.delete();
        decode_byte(ch, lst);
        if (typed)
            expected_chars.push_back(want);
        else
            foreach (step_res[i])
                expected_chars.push_back(step_res[i]);
        bytes_sent++;
        if (lst)
            strings_sent++;
    endtask

    task automatic send_filler(int n);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom_range(8'h27, 8'h7e)), 1'b0, 1'b0, '0);
    endtask

    task automatic send_text(string s, logic lst_at_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], lst_at_end && (i == s.len() - 1), 1'b0, '0);
    endtask

    // stop offering items, then wait for every expected result
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // receiver side
    always @(negedge clk)
    begin
        if (stall_taken != stall_asks)
        begin
            stall_taken = stall_asks;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= 21);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        decoded_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected item, out_char", m_axis_tdata, 0);
            end
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_axis_tdata != want.ch)
                    report_mismatch("out_char", m_axis_tdata, want.ch);
                if (m_axis_tuser[0] != want.valid)
                    report_mismatch("char_valid", m_axis_tuser[0], want.valid);
                if (m_axis_tlast != want.eos)
                    report_mismatch("end_of_string", m_axis_tlast, want.eos);
                if (m_axis_tuser[1] != want.trunc)
                    report_mismatch("truncated", m_axis_tuser[1], want.trunc);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_cnt, expected_chars.size());
            $display("html_entity_decoder: mismatch");
            $finish;
        end
    end

    initial
    begin
        int  tok_n;
        int  kind;
        int  e;
        int  cut;
        int  rand_start;
        bit  paused;
        logic [7:0] str_q [$];
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].ch, plan[i].lst, plan[i].typed, plan[i].want);

        // random strings, mostly entity-shaped
        stall_asks++;
        paused = 0;
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES)
        begin
            str_q.delete();
            tok_n = $urandom_range(1, 6);
            for (int t = 0; t < tok_n; t++)
            begin
                kind = $urandom_range(0, 9);
                e = $urandom_range(0, 4);
                if (kind <= 3)
                begin
                    for (int i = 0; i < entity_text[e].len(); i++)
                        str_q.push_back(entity_text[e][i]);
                end
                else if (kind <= 5)
                begin
                    cut = $urandom_range(1, entity_text[e].len() - 1);
                    for (int i = 0; i < cut; i++)
                        str_q.push_back(entity_text[e][i]);
                end
                else if (kind == 6)
                begin
                    str_q.push_back(AMP);
                end
                else
                begin
                    str_q.push_back(8'($urandom_range(1, 255)));
                end
            end
            foreach (str_q[i])
                send_item(str_q[i], i == str_q.size() - 1, 1'b0, '0);
            if (!paused && bytes_sent - rand_start >= RAND_BYTES / 2)
            begin
                paused = 1;
                wait_drained();
            end
        end

        // exactly at capacity, no idling on either side
        wait_drained();
        calm = 1;
        send_filler(CAPACITY - 2);
        send_text("&lt;", 1'b1);
        wait_drained();
        calm = 0;

        // over capacity: entity, literal and held bytes all dropped
        send_filler(CAPACITY - 1);
        send_text("&lt;Q&am", 1'b1);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch("items left over", expected_chars.size(), 0);

        $display("sent %0d strings, %0d bytes; checked %0d decoded items", strings_sent,
                 bytes_sent, chars_checked);
        $display("covered all five entities, broken and flushed holds, capacity edge");
        if (errors == 0)
            $display("html_entity_decoder: match");
        else
            $display("html_entity_decoder: mismatch");
        $finish;
    end

endmodule
